// File: rtl/taa_pkg.sv
// Package for the transformed_aabb block: fixed-point types, register indexes
// and reset values of the affine coefficient registers.
// No dependencies; used by taa_axis and transformed_aabb.
package taa_pkg;

  localparam int unsigned CoordW   = 32;
  localparam int unsigned ProdW    = 2 * CoordW;
  localparam int unsigned AccW     = ProdW + 2;
  localparam int unsigned FracBits = 16;
  localparam int unsigned RndW     = AccW - FracBits;
  localparam int unsigned RegW     = 64;
  localparam int unsigned IdxW     = 3;

  typedef logic signed [CoordW-1:0] fix_t;

  // One axis of a box after ordering: lo is never above hi.
  typedef struct packed {
    logic signed [CoordW-1:0] lo;
    logic signed [CoordW-1:0] hi;
  } span_t;

  typedef struct packed {
    span_t x;
    span_t y;
    span_t z;
  } box_t;

  // One row of the affine transform: three coefficients and a translation.
  typedef struct packed {
    logic signed [CoordW-1:0] m0;
    logic signed [CoordW-1:0] m1;
    logic signed [CoordW-1:0] m2;
    logic signed [CoordW-1:0] t;
  } row_t;

  typedef enum logic [IdxW-1:0] {
    REG_X_AB = 3'd0,
    REG_X_CT = 3'd1,
    REG_Y_AB = 3'd2,
    REG_Y_CT = 3'd3,
    REG_Z_AB = 3'd4,
    REG_Z_CT = 3'd5
  } reg_idx_t;

  // Reset values give the identity transform.
  localparam logic [RegW-1:0] XAbReset = 64'h0000_0000_0001_0000;
  localparam logic [RegW-1:0] XCtReset = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] YAbReset = 64'h0001_0000_0000_0000;
  localparam logic [RegW-1:0] YCtReset = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] ZAbReset = 64'h0000_0000_0000_0000;
  localparam logic [RegW-1:0] ZCtReset = 64'h0000_0000_0001_0000;

endpackage

// File: rtl/taa_axis.sv
// One output axis of the transformed box: three-stage multiply, sum and
// round/saturate pipeline for the minimum and maximum of that axis.
// Depends on taa_pkg.
module taa_axis (
  input  logic           clk,
  input  taa_pkg::row_t  row,
  input  taa_pkg::box_t  box,
  output taa_pkg::fix_t  lo,
  output taa_pkg::fix_t  hi
);

  logic signed [taa_pkg::CoordW-1:0] coef [3];
  taa_pkg::span_t                    span [3];

  logic signed [taa_pkg::ProdW-1:0]  pmin [3];
  logic signed [taa_pkg::ProdW-1:0]  pmax [3];
  logic signed [taa_pkg::CoordW-1:0] t_b;

  logic signed [taa_pkg::AccW-1:0]   sum_lo;
  logic signed [taa_pkg::AccW-1:0]   sum_hi;

  logic signed [taa_pkg::AccW-1:0]   rnd_lo;
  logic signed [taa_pkg::AccW-1:0]   rnd_hi;
  logic signed [taa_pkg::RndW-1:0]   q_lo;
  logic signed [taa_pkg::RndW-1:0]   q_hi;
  taa_pkg::fix_t                     lo_next;
  taa_pkg::fix_t                     hi_next;

  assign coef[0] = row.m0;
  assign coef[1] = row.m1;
  assign coef[2] = row.m2;
  assign span[0] = box.x;
  assign span[1] = box.y;
  assign span[2] = box.z;

  // Each term is linear in its coordinate, so its extremes over the eight
  // corners sit at the span ends; a negative coefficient swaps them.
  for (genvar j = 0; j < 3; j++) begin : g_term
    always_ff @(posedge clk) begin
      if (coef[j][taa_pkg::CoordW-1]) begin
        pmin[j] <= taa_pkg::ProdW'(coef[j]) * taa_pkg::ProdW'(span[j].hi);
        pmax[j] <= taa_pkg::ProdW'(coef[j]) * taa_pkg::ProdW'(span[j].lo);
      end else begin
        pmin[j] <= taa_pkg::ProdW'(coef[j]) * taa_pkg::ProdW'(span[j].lo);
        pmax[j] <= taa_pkg::ProdW'(coef[j]) * taa_pkg::ProdW'(span[j].hi);
      end
    end
  end

  always_ff @(posedge clk) begin
    t_b <= row.t;
  end

  always_ff @(posedge clk) begin
    sum_lo <= taa_pkg::AccW'(pmin[0]) + taa_pkg::AccW'(pmin[1]) + taa_pkg::AccW'(pmin[2])
            + $signed({{(taa_pkg::AccW - taa_pkg::CoordW - taa_pkg::FracBits){t_b[31]}},
                       t_b, {taa_pkg::FracBits{1'b0}}});
    sum_hi <= taa_pkg::AccW'(pmax[0]) + taa_pkg::AccW'(pmax[1]) + taa_pkg::AccW'(pmax[2])
            + $signed({{(taa_pkg::AccW - taa_pkg::CoordW - taa_pkg::FracBits){t_b[31]}},
                       t_b, {taa_pkg::FracBits{1'b0}}});
  end

  // Round to nearest with ties toward plus infinity, then saturate. Both
  // steps are monotone, so they preserve which corner gives the extreme.
  always_comb begin
    rnd_lo = sum_lo + $signed(taa_pkg::AccW'(1) <<< (taa_pkg::FracBits - 1));
    rnd_hi = sum_hi + $signed(taa_pkg::AccW'(1) <<< (taa_pkg::FracBits - 1));
    q_lo   = rnd_lo[taa_pkg::AccW-1:taa_pkg::FracBits];
    q_hi   = rnd_hi[taa_pkg::AccW-1:taa_pkg::FracBits];

    if (q_lo[taa_pkg::RndW-1:taa_pkg::CoordW-1] == '0 ||
        q_lo[taa_pkg::RndW-1:taa_pkg::CoordW-1] == '1) begin
      lo_next = q_lo[taa_pkg::CoordW-1:0];
    end else if (q_lo[taa_pkg::RndW-1]) begin
      lo_next = {1'b1, {(taa_pkg::CoordW-1){1'b0}}};
    end else begin
      lo_next = {1'b0, {(taa_pkg::CoordW-1){1'b1}}};
    end

    if (q_hi[taa_pkg::RndW-1:taa_pkg::CoordW-1] == '0 ||
        q_hi[taa_pkg::RndW-1:taa_pkg::CoordW-1] == '1) begin
      hi_next = q_hi[taa_pkg::CoordW-1:0];
    end else if (q_hi[taa_pkg::RndW-1]) begin
      hi_next = {1'b1, {(taa_pkg::CoordW-1){1'b0}}};
    end else begin
      hi_next = {1'b0, {(taa_pkg::CoordW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    lo <= lo_next;
    hi <= hi_next;
  end

endmodule

// File: rtl/transformed_aabb.sv
// Affine transform of an axis-aligned bounding box, signed Q16.16.
//
// Input: a box is transferred at a rising edge where start is high and busy
// is low. busy is always low, so a new box may be given in every cycle.
// Output: done is high for exactly one cycle per box, with out_lo_* and
// out_hi_* valid in that cycle. The receiver cannot stall; results must be
// taken as they come.
// Pipeline: one box per cycle through four stages: input ordering, 18
// parallel 32x32 multipliers, a four-input sum per extreme, and
// round/saturate into the output registers. done is carried alongside
// through the vld_a, vld_b and vld_c registers.
// Configuration: six 64-bit coefficient registers written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; cfg_ready is always high and
// indexes above five are ignored. Write them only while no box is in flight.
// Reset (rst, synchronous) restores the identity transform and drops any
// boxes in flight; no result is produced for them.
module transformed_aabb (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [31:0]            lo_x,
  input  logic signed [31:0]            lo_y,
  input  logic signed [31:0]            lo_z,
  input  logic signed [31:0]            hi_x,
  input  logic signed [31:0]            hi_y,
  input  logic signed [31:0]            hi_z,
  output logic                          done,
  output logic signed [31:0]            out_lo_x,
  output logic signed [31:0]            out_lo_y,
  output logic signed [31:0]            out_lo_z,
  output logic signed [31:0]            out_hi_x,
  output logic signed [31:0]            out_hi_y,
  output logic signed [31:0]            out_hi_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [taa_pkg::IdxW-1:0]      cfg_index,
  input  logic [taa_pkg::RegW-1:0]      cfg_data
);

  logic [taa_pkg::RegW-1:0] coef_x_ab;
  logic [taa_pkg::RegW-1:0] coef_x_ct;
  logic [taa_pkg::RegW-1:0] coef_y_ab;
  logic [taa_pkg::RegW-1:0] coef_y_ct;
  logic [taa_pkg::RegW-1:0] coef_z_ab;
  logic [taa_pkg::RegW-1:0] coef_z_ct;

  taa_pkg::row_t row_x;
  taa_pkg::row_t row_y;
  taa_pkg::row_t row_z;

  logic          accept;
  taa_pkg::box_t box;
  taa_pkg::box_t box_next;
  logic          vld_a;
  logic          vld_b;
  logic          vld_c;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x_ab <= taa_pkg::XAbReset;
      coef_x_ct <= taa_pkg::XCtReset;
      coef_y_ab <= taa_pkg::YAbReset;
      coef_y_ct <= taa_pkg::YCtReset;
      coef_z_ab <= taa_pkg::ZAbReset;
      coef_z_ct <= taa_pkg::ZCtReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (taa_pkg::reg_idx_t'(cfg_index))
        taa_pkg::REG_X_AB: coef_x_ab <= cfg_data;
        taa_pkg::REG_X_CT: coef_x_ct <= cfg_data;
        taa_pkg::REG_Y_AB: coef_y_ab <= cfg_data;
        taa_pkg::REG_Y_CT: coef_y_ct <= cfg_data;
        taa_pkg::REG_Z_AB: coef_z_ab <= cfg_data;
        taa_pkg::REG_Z_CT: coef_z_ct <= cfg_data;
        default: ;
      endcase
    end
  end

  assign row_x = '{m0: coef_x_ab[31:0], m1: coef_x_ab[63:32],
                   m2: coef_x_ct[31:0], t: coef_x_ct[63:32]};
  assign row_y = '{m0: coef_y_ab[31:0], m1: coef_y_ab[63:32],
                   m2: coef_y_ct[31:0], t: coef_y_ct[63:32]};
  assign row_z = '{m0: coef_z_ab[31:0], m1: coef_z_ab[63:32],
                   m2: coef_z_ct[31:0], t: coef_z_ct[63:32]};

  // Order each input axis so that an inverted box is handled like any other.
  always_comb begin
    box_next.x.lo = (lo_x < hi_x) ? lo_x : hi_x;
    box_next.x.hi = (lo_x < hi_x) ? hi_x : lo_x;
    box_next.y.lo = (lo_y < hi_y) ? lo_y : hi_y;
    box_next.y.hi = (lo_y < hi_y) ? hi_y : lo_y;
    box_next.z.lo = (lo_z < hi_z) ? lo_z : hi_z;
    box_next.z.hi = (lo_z < hi_z) ? hi_z : lo_z;
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      box <= box_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
      vld_b <= 1'b0;
      vld_c <= 1'b0;
      done  <= 1'b0;
    end else begin
      vld_a <= accept;
      vld_b <= vld_a;
      vld_c <= vld_b;
      done  <= vld_c;
    end
  end

  taa_axis u_axis_x (
    .clk (clk),
    .row (row_x),
    .box (box),
    .lo  (out_lo_x),
    .hi  (out_hi_x)
  );

  taa_axis u_axis_y (
    .clk (clk),
    .row (row_y),
    .box (box),
    .lo  (out_lo_y),
    .hi  (out_hi_y)
  );

  taa_axis u_axis_z (
    .clk (clk),
    .row (row_z),
    .box (box),
    .lo  (out_lo_z),
    .hi  (out_hi_z)
  );

`ifndef SYNTH
  a_lat_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("accepted box gave no result four cycles later");

  a_lat_back: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without a box accepted four cycles earlier");

  a_order: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_lo_x <= out_hi_x && out_lo_y <= out_hi_y && out_lo_z <= out_hi_z))
    else $error("transformed minimum above maximum");
`endif

endmodule

// File: tb/transformed_aabb_checker.sv
// Checker for transformed_aabb: follows the coefficient writes, predicts the
// enclosing box of every transferred input box and compares each result.
// Depends on taa_pkg for the coordinate, row and box types and register codes.
`timescale 1ns / 100ps

module transformed_aabb_checker
  import taa_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  fix_t                lo_x,
  input  fix_t                lo_y,
  input  fix_t                lo_z,
  input  fix_t                hi_x,
  input  fix_t                hi_y,
  input  fix_t                hi_z,
  input  logic                done,
  input  fix_t                out_lo_x,
  input  fix_t                out_lo_y,
  input  fix_t                out_lo_z,
  input  fix_t                out_hi_x,
  input  fix_t                out_hi_y,
  input  fix_t                out_hi_z,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [IdxW-1:0]     cfg_index,
  input  logic [RegW-1:0]     cfg_data,
  output int                  mismatches,
  output int                  pending
);

  localparam fix_t FixMax = 32'sh7FFF_FFFF;
  localparam fix_t FixMin = 32'sh8000_0000;

  logic [RegW-1:0] coef_x_ab, coef_x_ct;
  logic [RegW-1:0] coef_y_ab, coef_y_ct;
  logic [RegW-1:0] coef_z_ab, coef_z_ct;

  box_t expected_boxes[$];
  int   mismatch_count = 0;

  function automatic row_t make_row(logic [RegW-1:0] ab, logic [RegW-1:0] ct);
    row_t r;
    r.m0 = ab[31:0];
    r.m1 = ab[63:32];
    r.m2 = ct[31:0];
    r.t  = ct[63:32];
    return r;
  endfunction

  // The sum is exact at 68 bits; adding half a unit and shifting right
  // rounds to nearest with ties toward plus infinity.
  function automatic fix_t transform_coord(row_t r, fix_t x, fix_t y, fix_t z);
    logic signed [67:0] wm0, wm1, wm2, wt, wx, wy, wz;
    logic signed [67:0] acc;
    logic signed [67:0] q;
    wm0 = 68'(r.m0);
    wm1 = 68'(r.m1);
    wm2 = 68'(r.m2);
    wt  = 68'(r.t);
    wx  = 68'(x);
    wy  = 68'(y);
    wz  = 68'(z);
    acc = wm0 * wx + wm1 * wy + wm2 * wz + (wt <<< FracBits) + 68'sd32768;
    q = acc >>> FracBits;
    if (q > 68'sd2147483647) return FixMax;
    if (q < -68'sd2147483648) return FixMin;
    return fix_t'(q[31:0]);
  endfunction

  function automatic box_t transform_box(box_t b);
    box_t r;
    row_t rx, ry, rz;
    fix_t cx, cy, cz;
    fix_t v[3];
    fix_t mn[3];
    fix_t mx[3];
    int   c, a;
    rx = make_row(coef_x_ab, coef_x_ct);
    ry = make_row(coef_y_ab, coef_y_ct);
    rz = make_row(coef_z_ab, coef_z_ct);
    for (c = 0; c < 8; c++) begin
      cx = ((c & 1) != 0) ? b.x.hi : b.x.lo;
      cy = ((c & 2) != 0) ? b.y.hi : b.y.lo;
      cz = ((c & 4) != 0) ? b.z.hi : b.z.lo;
      v[0] = transform_coord(rx, cx, cy, cz);
      v[1] = transform_coord(ry, cx, cy, cz);
      v[2] = transform_coord(rz, cx, cy, cz);
      for (a = 0; a < 3; a++) begin
        if (c == 0 || v[a] < mn[a]) mn[a] = v[a];
        if (c == 0 || v[a] > mx[a]) mx[a] = v[a];
      end
    end
    r.x.lo = mn[0];
    r.x.hi = mx[0];
    r.y.lo = mn[1];
    r.y.hi = mx[1];
    r.z.lo = mn[2];
    r.z.hi = mx[2];
    return r;
  endfunction

  task automatic check_field(string name, fix_t want, fix_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    box_t in_box;
    box_t want;
    if (rst) begin
      coef_x_ab = XAbReset;
      coef_x_ct = XCtReset;
      coef_y_ab = YAbReset;
      coef_y_ct = YCtReset;
      coef_z_ab = ZAbReset;
      coef_z_ct = ZCtReset;
      expected_boxes.delete();
    end else begin
      if (done) begin
        if (expected_boxes.size() == 0) begin
          $error("result transfer with no box outstanding");
          mismatch_count++;
        end else begin
          want = expected_boxes.pop_front();
          check_field("out_lo_x", want.x.lo, out_lo_x);
          check_field("out_lo_y", want.y.lo, out_lo_y);
          check_field("out_lo_z", want.z.lo, out_lo_z);
          check_field("out_hi_x", want.x.hi, out_hi_x);
          check_field("out_hi_y", want.y.hi, out_hi_y);
          check_field("out_hi_z", want.z.hi, out_hi_z);
        end
      end
      if (start && !busy) begin
        in_box.x.lo = lo_x;
        in_box.y.lo = lo_y;
        in_box.z.lo = lo_z;
        in_box.x.hi = hi_x;
        in_box.y.hi = hi_y;
        in_box.z.hi = hi_z;
        expected_boxes.push_back(transform_box(in_box));
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_X_AB: coef_x_ab = cfg_data;
          REG_X_CT: coef_x_ct = cfg_data;
          REG_Y_AB: coef_y_ab = cfg_data;
          REG_Y_CT: coef_y_ct = cfg_data;
          REG_Z_AB: coef_z_ab = cfg_data;
          REG_Z_CT: coef_z_ct = cfg_data;
          default: ;
        endcase
      end
    end
    pending    <= expected_boxes.size();
    mismatches <= mismatch_count;
  end

endmodule

// File: tb/transformed_aabb_tb.sv
// Top of the transformed_aabb testbench: clock, reset, box and coefficient
// stimulus, watchdog and verdict. Depends on taa_pkg, the block itself and
// transformed_aabb_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module transformed_aabb_tb;
  import taa_pkg::*;

  localparam fix_t FixMax     = 32'sh7FFF_FFFF;
  localparam fix_t FixMin     = 32'sh8000_0000;
  localparam fix_t One        = 32'sh0001_0000;
  localparam int   NumPhases  = 8;
  localparam int   PhaseItems = 150;
  localparam int   DrainHold  = 8;
  localparam int   IdleLimit  = 1000;

  // Indexes past the last register; writes to them must change nothing.
  localparam logic [IdxW-1:0] IdxSpareLo = 3'd6;
  localparam logic [IdxW-1:0] IdxSpareHi = 3'd7;

  typedef enum int {CoefFull, CoefSmall, CoefEdge, CoefMixed} coef_mode_t;

  logic            clk       = 1'b0;
  logic            rst       = 1'b1;
  logic            start     = 1'b0;
  logic            busy;
  fix_t            lo_x      = '0;
  fix_t            lo_y      = '0;
  fix_t            lo_z      = '0;
  fix_t            hi_x      = '0;
  fix_t            hi_y      = '0;
  fix_t            hi_z      = '0;
  logic            done;
  fix_t            out_lo_x, out_lo_y, out_lo_z;
  fix_t            out_hi_x, out_hi_y, out_hi_z;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [IdxW-1:0] cfg_index = '0;
  logic [RegW-1:0] cfg_data  = '0;
  int              mismatches;
  int              pending;

  int boxes_sent   = 0;
  int reg_writes   = 0;
  int coef_loads   = 0;
  int idle_cycles  = 0;

  transformed_aabb DUT (.*);

  transformed_aabb_checker checker_inst (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Watchdog: no transfer for %0d cycles", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic box_t make_box(fix_t lx, fix_t ly, fix_t lz,
                                    fix_t hx, fix_t hy, fix_t hz);
    box_t b;
    b.x.lo = lx;
    b.y.lo = ly;
    b.z.lo = lz;
    b.x.hi = hx;
    b.y.hi = hy;
    b.z.hi = hz;
    return b;
  endfunction

  function automatic fix_t pick_edge();
    case ($urandom_range(0, 4))
      0: return FixMax;
      1: return FixMin;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic fix_t rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return fix_t'($urandom);
    if (r < 8) return fix_t'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    return pick_edge();
  endfunction

  function automatic box_t rand_box();
    return make_box(rand_coord(), rand_coord(), rand_coord(),
                    rand_coord(), rand_coord(), rand_coord());
  endfunction

  function automatic fix_t rand_half(coef_mode_t mode);
    coef_mode_t m;
    m = mode;
    if (m == CoefMixed) m = coef_mode_t'($urandom_range(0, 2));
    case (m)
      CoefSmall: return fix_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      CoefEdge:  return pick_edge();
      default:   return fix_t'($urandom);
    endcase
  endfunction

  function automatic logic [RegW-1:0] rand_coef(coef_mode_t mode);
    return {rand_half(mode), rand_half(mode)};
  endfunction

  // Mostly back-to-back or short gaps, with the odd long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Holds start high until the transfer; start stays high if no gap follows.
  task automatic send_box(box_t b, int gap);
    start <= 1'b1;
    lo_x  <= b.x.lo;
    lo_y  <= b.y.lo;
    lo_z  <= b.z.lo;
    hi_x  <= b.x.hi;
    hi_y  <= b.y.hi;
    hi_z  <= b.z.hi;
    @(posedge clk);
    while (busy) @(posedge clk);
    boxes_sent++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainHold) @(posedge clk);
  endtask

  task automatic write_reg(logic [IdxW-1:0] idx, logic [RegW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
  endtask

  // Only called with no box in flight.
  task automatic load_coefs(logic [RegW-1:0] xab, logic [RegW-1:0] xct,
                            logic [RegW-1:0] yab, logic [RegW-1:0] yct,
                            logic [RegW-1:0] zab, logic [RegW-1:0] zct);
    write_reg(REG_X_AB, xab);
    write_reg(REG_X_CT, xct);
    write_reg(REG_Y_AB, yab);
    write_reg(REG_Y_CT, yct);
    write_reg(REG_Z_AB, zab);
    write_reg(REG_Z_CT, zct);
    write_reg(IdxSpareLo, {$urandom, $urandom});
    write_reg(IdxSpareHi, {$urandom, $urandom});
    cfg_valid <= 1'b0;
    coef_loads++;
  endtask

  initial begin : stimulus
    coef_mode_t mode;
    logic       no_gaps;
    int         p, n;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Identity transform straight out of reset.
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);
    send_box(make_box(FixMin, FixMin, FixMin, FixMax, FixMax, FixMax), 0);
    send_box(make_box(FixMax, FixMax, FixMax, FixMin, FixMin, FixMin), 1);
    send_box(make_box(-32'sd1, -32'sd1, -32'sd1, 32'sd1, 32'sd1, 32'sd1), 0);
    send_box(make_box(One, -One, 32'sh0001_8000, -One, One, -32'sh0001_8000), 2);
    send_box(make_box(32'sh0001_8000, 32'sh0000_8000, -32'sh0000_8000,
                      32'sh0003_4000, 32'sh0000_8001, 32'sh0000_7FFF), 0);

    // Largest positive coefficients and translations drive saturation.
    wait_drain();
    load_coefs({FixMax, FixMax}, {FixMax, FixMax}, {FixMax, FixMax},
               {FixMax, FixMax}, {FixMax, FixMax}, {FixMax, FixMax});
    send_box(make_box(0, 0, 0, 0, 0, 0), 0);
    send_box(make_box(FixMin, FixMin, FixMin, FixMax, FixMax, FixMax), 0);
    send_box(make_box(-One, 0, 0, 0, 0, 0), 0);

    wait_drain();
    load_coefs({FixMin, FixMin}, {FixMin, FixMin}, {FixMin, FixMin},
               {FixMin, FixMin}, {FixMin, FixMin}, {FixMin, FixMin});
    send_box(make_box(FixMin, FixMin, FixMin, FixMin, FixMin, FixMin), 0);
    send_box(make_box(FixMax, FixMin, FixMax, FixMin, FixMax, FixMin), 0);
    send_box(make_box(0, 0, 0, 32'sd1, 32'sd1, 32'sd1), 0);

    // Half-unit products land exactly on the rounding tie.
    wait_drain();
    load_coefs({32'h0000_0000, 32'h0000_8000}, 64'd0,
               {32'hFFFF_8000, 32'h0000_0000}, 64'd0,
               64'd0, {32'h0001_0000, 32'h0000_8000});
    send_box(make_box(32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1), 0);
    send_box(make_box(-32'sd1, -32'sd1, -32'sd1, 32'sd3, 32'sd3, 32'sd3), 0);
    send_box(make_box(-32'sd3, 32'sd5, -32'sd1, 32'sd1, -32'sd3, 32'sd7), 0);

    for (p = 0; p < NumPhases; p++) begin
      wait_drain();
      if (p == NumPhases - 1) begin
        load_coefs(XAbReset, XCtReset, YAbReset, YCtReset, ZAbReset, ZCtReset);
      end else begin
        mode = coef_mode_t'(p % 4);
        load_coefs(rand_coef(mode), rand_coef(mode), rand_coef(mode),
                   rand_coef(mode), rand_coef(mode), rand_coef(mode));
      end
      no_gaps = 1'b0;
      for (n = 0; n < PhaseItems; n++) begin
        if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        if ($urandom_range(0, 119) == 0) wait_drain();
        send_box(rand_box(), no_gaps ? 0 : pick_gap());
      end
    end

    wait_drain();
    $display("Sent %0d boxes under %0d coefficient sets (%0d register writes).",
             boxes_sent, coef_loads + 1, reg_writes);
    $display("Sets covered identity, saturating extremes, rounding ties and random.");
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
